// ===== rtl/core/s5rc_pkg.sv =====
package s5rc_pkg;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_MVER  = 8'b0000_0010,
        PH_MSEL  = 8'b0000_0100,
        PH_AVER  = 8'b0000_1000,
        PH_ASTAT = 8'b0001_0000,
        PH_HEAD  = 8'b0010_0000,
        PH_DLEN  = 8'b0100_0000,
        PH_SKIP  = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        EV_SEND_CRED    = 2'd0,
        EV_SEND_CONNECT = 2'd1,
        EV_SUCCESS      = 2'd2,
        EV_FAILURE      = 2'd3
    } event_t;

    localparam logic [3:0] ERR_NONE             = 4'd0;
    localparam logic [3:0] ERR_METHOD_VERSION   = 4'd1;
    localparam logic [3:0] ERR_NO_METHOD        = 4'd2;
    localparam logic [3:0] ERR_UNSUPPORTED      = 4'd3;
    localparam logic [3:0] ERR_AUTH_REJECTED    = 4'd4;
    localparam logic [3:0] ERR_REPLY_VERSION    = 4'd5;
    localparam logic [3:0] ERR_ADDR_TYPE        = 4'd6;
    localparam logic [3:0] ERR_PROXY_REFUSED    = 4'd7;
    localparam logic [3:0] ERR_NO_METHOD_NOCRED = 4'd8;

    localparam logic [7:0] SOCKS_VERSION   = 8'h05;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] METHOD_REJECT   = 8'hFF;
    localparam logic [7:0] AUTH_OK         = 8'h00;
    localparam logic [7:0] REP_SUCCEEDED   = 8'h00;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;

    localparam int SKIP_W = 9;
    localparam logic [SKIP_W-1:0] SKIP_IPV4 = 9'd6;
    localparam logic [SKIP_W-1:0] SKIP_IPV6 = 9'd18;
    localparam logic [SKIP_W-1:0] SKIP_PORT = 9'd2;

    localparam logic kind_START = 1'b0;

    typedef struct packed {
        phase_t            phase;
        logic [1:0]        byte_count;
        logic [SKIP_W-1:0] bytes_to_skip;
        logic [7:0]        saved_reply;
        logic [7:0]        saved_method;
    } state_t;

    typedef struct packed {
        logic       valid;
        event_t     event_res;
        logic [3:0] error_code;
        logic [7:0] reply_code;
    } result_t;

endpackage

// ===== rtl/core/s5rc_step.sv =====
module s5rc_step (
    input  s5rc_pkg::state_t  cur,
    input  logic              kind,
    input  logic [7:0]        rx_byte,
    input  logic              offer_credentials,
    output s5rc_pkg::state_t  nxt,
    output s5rc_pkg::result_t res
);
    import s5rc_pkg::*;

    function automatic result_t make_res(event_t ev, logic [3:0] err, logic [7:0] rep);
        result_t r;
        r.valid      = 1'b1;
        r.event_res  = ev;
        r.error_code = err;
        r.reply_code = rep;
        return r;
    endfunction

    function automatic result_t verdict(logic [7:0] rep);
        result_t r;
        if (rep == REP_SUCCEEDED)
        begin
            r = make_res(EV_SUCCESS, ERR_NONE, 8'd0);
        end
        else
        begin
            r = make_res(EV_FAILURE, ERR_PROXY_REFUSED, rep);
        end
        return r;
    endfunction

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (kind == kind_START)
        begin
            nxt.phase         = PH_MVER;
            nxt.byte_count    = 2'd0;
            nxt.bytes_to_skip = '0;
            nxt.saved_reply   = 8'd0;
            nxt.saved_method  = 8'd0;
        end
        else
        begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    nxt.phase = PH_IDLE;
                end
                PH_MVER:
                begin
                    nxt.saved_method = rx_byte;
                    nxt.phase        = PH_MSEL;
                end
                PH_MSEL:
                begin
                    if (cur.saved_method != SOCKS_VERSION)
                    begin
                        nxt.phase = PH_IDLE;
                        res = make_res(EV_FAILURE, ERR_METHOD_VERSION, 8'd0);
                    end
                    else if (rx_byte == METHOD_REJECT)
                    begin
                        nxt.phase = PH_IDLE;
                        res = make_res(EV_FAILURE,
                                       offer_credentials ? ERR_NO_METHOD : ERR_NO_METHOD_NOCRED,
                                       8'd0);
                    end
                    else if (rx_byte == METHOD_USERPASS)
                    begin
                        nxt.phase = PH_AVER;
                        res = make_res(EV_SEND_CRED, ERR_NONE, 8'd0);
                    end
                    else if (rx_byte == METHOD_NONE)
                    begin
                        nxt.phase      = PH_HEAD;
                        nxt.byte_count = 2'd0;
                        res = make_res(EV_SEND_CONNECT, ERR_NONE, 8'd0);
                    end
                    else
                    begin
                        nxt.phase = PH_IDLE;
                        res = make_res(EV_FAILURE, ERR_UNSUPPORTED, 8'd0);
                    end
                end
                PH_AVER:
                begin
                    nxt.phase = PH_ASTAT;
                end
                PH_ASTAT:
                begin
                    if (rx_byte != AUTH_OK)
                    begin
                        nxt.phase = PH_IDLE;
                        res = make_res(EV_FAILURE, ERR_AUTH_REJECTED, 8'd0);
                    end
                    else
                    begin
                        nxt.phase      = PH_HEAD;
                        nxt.byte_count = 2'd0;
                        res = make_res(EV_SEND_CONNECT, ERR_NONE, 8'd0);
                    end
                end
                PH_HEAD:
                begin
                    if (cur.byte_count == 2'd0)
                    begin
                        nxt.saved_method = rx_byte;
                    end
                    if (cur.byte_count == 2'd1)
                    begin
                        nxt.saved_reply = rx_byte;
                    end
                    if (cur.byte_count != 2'd3)
                    begin
                        nxt.byte_count = cur.byte_count + 2'd1;
                    end
                    else
                    begin
                        nxt.byte_count = 2'd0;
                        if (cur.saved_method != SOCKS_VERSION)
                        begin
                            nxt.phase = PH_IDLE;
                            res = make_res(EV_FAILURE, ERR_REPLY_VERSION, 8'd0);
                        end
                        else if (rx_byte == ATYP_IPV4)
                        begin
                            nxt.bytes_to_skip = SKIP_IPV4;
                            nxt.phase         = PH_SKIP;
                        end
                        else if (rx_byte == ATYP_IPV6)
                        begin
                            nxt.bytes_to_skip = SKIP_IPV6;
                            nxt.phase         = PH_SKIP;
                        end
                        else if (rx_byte == ATYP_DOMAIN)
                        begin
                            nxt.phase = PH_DLEN;
                        end
                        else if (cur.saved_reply == REP_SUCCEEDED)
                        begin
                            nxt.phase = PH_IDLE;
                            res = make_res(EV_FAILURE, ERR_ADDR_TYPE, 8'd0);
                        end
                        else
                        begin
                            nxt.phase = PH_IDLE;
                            res = verdict(cur.saved_reply);
                        end
                    end
                end
                PH_DLEN:
                begin
                    nxt.bytes_to_skip = {1'b0, rx_byte} + SKIP_PORT;
                    nxt.phase         = PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (cur.bytes_to_skip > 9'd1)
                    begin
                        nxt.bytes_to_skip = cur.bytes_to_skip - 9'd1;
                    end
                    else
                    begin
                        nxt.bytes_to_skip = '0;
                        nxt.phase         = PH_IDLE;
                        res = verdict(cur.saved_reply);
                    end
                end
                default:
                begin
                    nxt.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/socks5_client_reply_checker.sv =====
// Client-side SOCKS5 reply checker. Send a word with kind 0 to start a
// handshake, then one word per byte received from the proxy (kind 1). Results
// come out as send-credentials, send-connect, success or failure with an error
// code and the REP byte; bytes seen while idle or after a final result are
// dropped. offer_credentials is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while no word is in flight, which the block does not enforce.
// One word is taken every clock cycle while the result register is not held by
// a low out_ready; each word passes an input register and then the combinational
// phase and counter update into the result register.
module socks5_client_reply_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_res,
    output logic [3:0] error_code,
    output logic [7:0] reply_code
);
    import s5rc_pkg::*;

    logic       offer_reg;
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;
    logic       out_valid_reg;
    event_t     out_event_reg;
    logic [3:0] out_error_reg;
    logic [7:0] out_reply_reg;
    logic       proc_adv;

    assign proc_adv = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proc_adv;

    s5rc_step u_step (
        .cur               (state_reg),
        .kind              (in_kind_reg),
        .rx_byte           (in_byte_reg),
        .offer_credentials (offer_reg),
        .nxt               (state_next),
        .res               (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offer_reg     <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{PH_IDLE, 2'd0, '0, 8'd0, 8'd0};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offer_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (proc_adv)
            begin
                state_reg     <= state_next;
                out_valid_reg <= step_res.valid;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_kind_reg <= kind;
            in_byte_reg <= rx_byte;
        end
        if (proc_adv && step_res.valid)
        begin
            out_event_reg <= step_res.event_res;
            out_error_reg <= step_res.error_code;
            out_reply_reg <= step_res.reply_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = out_event_reg;
    assign error_code = out_error_reg;
    assign reply_code = out_reply_reg;

    a_err_only_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg != EV_FAILURE) |-> out_error_reg == ERR_NONE)
        else $error("error code on a non-failure word");

    a_rep_only_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reply_reg != 8'd0) |-> out_error_reg == ERR_PROXY_REFUSED)
        else $error("reply code without proxy refusal");

    a_start_enters_mver: assert property (@(posedge clk) disable iff (!rst_n)
        proc_adv && (in_kind_reg == kind_START) |=> state_reg.phase == PH_MVER)
        else $error("start word did not restart the handshake");

    a_skip_only_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_SKIP |-> state_reg.bytes_to_skip == '0)
        else $error("skip count left outside skip phase");

endmodule
